@@ hw/rtl/cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, codes and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int MAX_ROM_BANKS_DEF = 32;
    localparam int MAX_RAM_BANKS_DEF = 4;

    // byte offset bits inside one bank
    localparam int ROM_BANK_W = 14;
    localparam int RAM_BANK_W = 13;

    // address widths at the largest configuration
    localparam int ROM_ADDR_W = 19;
    localparam int RAM_ADDR_W = 15;

    localparam int CFG_DATA_W = 3;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ROM_RANGE = 2'd1,
        ST_RAM_RANGE = 2'd2,
        ST_UNMAPPED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SRC_FIXED = 2'd0,
        SRC_ROM   = 2'd1,
        SRC_RAM   = 2'd2
    } src_t;

    typedef enum logic {
        CFG_ROM_SIZE = 1'b0,
        CFG_RAM_SIZE = 1'b1
    } cfg_index_t;

    // 8 KiB windows of the bus address space, address bits 15:13
    typedef enum logic [2:0] {
        WIN_RAM_EN   = 3'd0,
        WIN_ROM_BANK = 3'd1,
        WIN_UPPER    = 3'd2,
        WIN_MODE     = 3'd3,
        WIN_VRAM     = 3'd4,
        WIN_EXT_RAM  = 3'd5,
        WIN_WRAM     = 3'd6,
        WIN_HIGH     = 3'd7
    } window_t;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;

    // one decoded request, as handed from the bank logic to the datapath
    typedef struct packed {
        logic                  rom_we;
        logic                  rom_re;
        logic [ROM_ADDR_W-1:0] rom_addr;
        logic                  ram_we;
        logic                  ram_re;
        logic [RAM_ADDR_W-1:0] ram_addr;
        logic [7:0]            wdata;
        src_t                  src;
        status_t               status;
    } cbm_access_t;

    // value mod m for every 5-bit value, evaluated at elaboration
    function automatic logic [32*5-1:0] mod_table(input int m);
        logic [32*5-1:0] t;
        int r;
        t = '0;
        for (int i = 0; i < 32; i++)
        begin
            r = i;
            for (int k = 0; k < 32; k++)
            begin
                if (r >= m)
                begin
                    r = r - m;
                end
            end
            t[i*5 +: 5] = 5'(r);
        end
        return t;
    endfunction

endpackage

@@ hw/rtl/cbm_req_if.sv @@
// ----------------------------------------------------------------------------
// cbm_req_if
// Request channel: bus read, bus write or ROM load.
// ----------------------------------------------------------------------------
interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] bus_address;
    logic [18:0] rom_load_address;
    logic [7:0]  data_byte;

    modport source (output valid, output cmd, output bus_address,
                    output rom_load_address, output data_byte, input ready);
    modport sink   (input valid, input cmd, input bus_address,
                    input rom_load_address, input data_byte, output ready);
endinterface

@@ hw/rtl/cbm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cbm_rsp_if
// Response channel: read byte and status, one per request.
// ----------------------------------------------------------------------------
interface cbm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] status;

    modport source (output valid, output read_data, output status, input ready);
    modport sink   (input valid, input read_data, input status, output ready);
endinterface

@@ hw/rtl/cbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbm_ctrl
// Size and bank registers and the address decode of one request.
// ----------------------------------------------------------------------------
module cbm_ctrl #(
    parameter int MAX_ROM_BANKS = cbm_pkg::MAX_ROM_BANKS_DEF,
    parameter int MAX_RAM_BANKS = cbm_pkg::MAX_RAM_BANKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          accept,
    input  logic [1:0]                    cmd,
    input  logic [15:0]                   bus_address,
    input  logic [18:0]                   rom_load_address,
    input  logic [7:0]                    data_byte,
    output cbm_pkg::cbm_access_t          dec
);
    import cbm_pkg::*;

    localparam logic [32*5-1:0] MOD_TAB = mod_table(MAX_ROM_BANKS);

    logic [2:0] rom_code_reg, rom_code_next;
    logic [1:0] ram_code_reg, ram_code_next;
    logic       ram_en_reg, ram_en_next;
    logic [4:0] rom_bank_reg, rom_bank_next;
    logic [1:0] upper_reg, upper_next;
    logic       mode_reg, mode_next;

    logic [8:0] rom_raw;
    logic       rom_capped;
    logic [8:0] rom_cnt;
    logic [2:0] ram_cnt;
    logic [4:0] bank_wr;
    logic [6:0] low_bank;
    logic [1:0] ram_bank;
    window_t    win;
    cmd_t       op;

    always_comb
    begin
        rom_raw    = 9'd2 << rom_code_reg;
        rom_capped = rom_raw > 9'(MAX_ROM_BANKS);
        rom_cnt    = rom_capped ? 9'(MAX_ROM_BANKS) : rom_raw;
        case (ram_code_reg)
            2'd2:    ram_cnt = 3'd1;
            2'd3:    ram_cnt = 3'd4;
            default: ram_cnt = 3'd0;
        endcase
        if (ram_cnt > 3'(MAX_RAM_BANKS))
        begin
            ram_cnt = 3'(MAX_RAM_BANKS);
        end
    end

    always_comb
    begin
        rom_code_next = rom_code_reg;
        ram_code_next = ram_code_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROM_SIZE: rom_code_next = cfg_data[2:0];
                CFG_RAM_SIZE: ram_code_next = cfg_data[1:0];
                default:      rom_code_next = rom_code_reg;
            endcase
        end
    end

    always_comb
    begin
        op       = cmd_t'(cmd);
        win      = window_t'(bus_address[15:13]);
        low_bank = mode_reg ? {upper_reg, 5'd0} : 7'd0;
        ram_bank = mode_reg ? upper_reg : 2'd0;
        bank_wr  = (data_byte[4:0] == 5'd0) ? 5'd1 : data_byte[4:0];

        ram_en_next   = ram_en_reg;
        rom_bank_next = rom_bank_reg;
        upper_next    = upper_reg;
        mode_next     = mode_reg;

        dec          = '0;
        dec.wdata    = data_byte;
        dec.src      = SRC_FIXED;
        dec.status   = ST_OK;
        dec.rom_addr = {bank_wr, bus_address[13:0]};
        dec.ram_addr = {ram_bank, bus_address[12:0]};

        case (op)
            CMD_READ:
            begin
                if (!bus_address[15])
                begin
                    if (!bus_address[14])
                    begin
                        dec.rom_addr = {low_bank[4:0], bus_address[13:0]};
                        if ({2'd0, low_bank} < rom_cnt)
                        begin
                            dec.rom_re = 1'b1;
                            dec.src    = SRC_ROM;
                        end
                        else
                        begin
                            dec.status = ST_ROM_RANGE;
                        end
                    end
                    else
                    begin
                        dec.rom_addr = {rom_bank_reg, bus_address[13:0]};
                        if ({4'd0, rom_bank_reg} < rom_cnt)
                        begin
                            dec.rom_re = 1'b1;
                            dec.src    = SRC_ROM;
                        end
                        else
                        begin
                            dec.status = ST_ROM_RANGE;
                        end
                    end
                end
                else if (win == WIN_EXT_RAM)
                begin
                    if (ram_en_reg)
                    begin
                        if ({1'b0, ram_bank} < ram_cnt)
                        begin
                            dec.ram_re = 1'b1;
                            dec.src    = SRC_RAM;
                        end
                        else
                        begin
                            dec.status = ST_RAM_RANGE;
                        end
                    end
                end
                else
                begin
                    dec.status = ST_UNMAPPED;
                end
            end
            CMD_WRITE:
            begin
                case (win)
                    WIN_RAM_EN:   ram_en_next = (data_byte[3:0] == RAM_EN_KEY);
                    WIN_ROM_BANK: rom_bank_next = rom_capped ? MOD_TAB[bank_wr*5 +: 5]
                                                  : (bank_wr & 5'(rom_raw - 9'd1));
                    WIN_UPPER:    upper_next = data_byte[1:0];
                    WIN_MODE:     mode_next = data_byte[0];
                    WIN_EXT_RAM:
                    begin
                        if (ram_en_reg)
                        begin
                            if ({1'b0, ram_bank} < ram_cnt)
                            begin
                                dec.ram_we = 1'b1;
                            end
                            else
                            begin
                                dec.status = ST_RAM_RANGE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_LOAD:
            begin
                dec.rom_addr = rom_load_address;
                if ({4'd0, rom_load_address[18:14]} < rom_cnt)
                begin
                    dec.rom_we = 1'b1;
                end
                else
                begin
                    dec.status = ST_ROM_RANGE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_code_reg <= 3'd0;
            ram_code_reg <= 2'd0;
            ram_en_reg   <= 1'b0;
            rom_bank_reg <= 5'd1;
            upper_reg    <= 2'd0;
            mode_reg     <= 1'b0;
        end
        else
        begin
            rom_code_reg <= rom_code_next;
            ram_code_reg <= ram_code_next;
            if (accept)
            begin
                ram_en_reg   <= ram_en_next;
                rom_bank_reg <= rom_bank_next;
                upper_reg    <= upper_next;
                mode_reg     <= mode_next;
            end
        end
    end

endmodule

@@ hw/rtl/cbm_rom.sv @@
// ----------------------------------------------------------------------------
// cbm_rom
// Synchronous ROM image store, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module cbm_rom #(
    parameter int DEPTH = cbm_pkg::MAX_ROM_BANKS_DEF * (1 << cbm_pkg::ROM_BANK_W),
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    q
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            q <= mem[addr];
        end
    end

endmodule

@@ hw/rtl/cbm_ram.sv @@
// ----------------------------------------------------------------------------
// cbm_ram
// Cartridge RAM store with a zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module cbm_ram #(
    parameter int DEPTH = cbm_pkg::MAX_RAM_BANKS_DEF * (1 << cbm_pkg::RAM_BANK_W),
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    q,
    output logic          busy
);
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          busy_reg, busy_next;
    logic [7:0]    mem [DEPTH];

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= 8'd0;
        end
        else if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            q <= mem[addr];
        end
    end

    assign busy = busy_reg;

endmodule

@@ hw/rtl/cartridge_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Banked cartridge controller: ROM image, battery-less RAM, bank registers.
// ----------------------------------------------------------------------------
// req carries bus reads, bus writes and ROM load bytes; rsp returns one
// read byte and status for every request, in order. Writes below 0x8000
// set the RAM enable, ROM bank, upper bank bits and banking mode; reads of
// 0x0000-0x7FFF and 0xA000-0xBFFF map through them into the stores.
// cfg_we/cfg_index/cfg_data set the ROM and RAM size codes; the user must
// write them only while no request is in flight, which the block itself
// does not enforce. One request per cycle sustained while rsp is ready and
// the RAM sweep is done; a result passes through the synchronous memory
// read and then the output register before it shows on rsp. When rsp
// stalls, one result waits in the output register and one more request is
// taken into the read stage; then req stalls until the output drains.
// After reset the RAM is swept to zero, one byte per cycle, over all
// MAX_RAM_BANKS * 8192 bytes; req.ready stays low during the sweep, size
// writes are still taken. Bank registers return to bank 1, RAM disabled.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper #(
    parameter int MAX_ROM_BANKS = cbm_pkg::MAX_ROM_BANKS_DEF,
    parameter int MAX_RAM_BANKS = cbm_pkg::MAX_RAM_BANKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data,
    cbm_req_if.sink                        req,
    cbm_rsp_if.source                      rsp
);
    import cbm_pkg::*;

    localparam int ROM_DEPTH = MAX_ROM_BANKS * (1 << ROM_BANK_W);
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int RAM_DEPTH = MAX_RAM_BANKS * (1 << RAM_BANK_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    cbm_access_t dec;
    logic        accept;
    logic        clear_busy;
    logic [7:0]  rom_q;
    logic [7:0]  ram_q;

    logic        s1_valid_reg, s1_valid_next;
    src_t        s1_src_reg;
    status_t     s1_status_reg;
    logic        s2_valid_reg, s2_valid_next;
    logic [7:0]  s2_data_reg;
    status_t     s2_status_reg;
    logic        s1_move;
    logic [7:0]  s1_data;

    assign s1_move   = s1_valid_reg && (!s2_valid_reg || rsp.ready);
    assign req.ready = !clear_busy && (!s1_valid_reg || !s2_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    cbm_ctrl #(
        .MAX_ROM_BANKS (MAX_ROM_BANKS),
        .MAX_RAM_BANKS (MAX_RAM_BANKS)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .accept           (accept),
        .cmd              (req.cmd),
        .bus_address      (req.bus_address),
        .rom_load_address (req.rom_load_address),
        .data_byte        (req.data_byte),
        .dec              (dec)
    );

    cbm_rom #(
        .DEPTH (ROM_DEPTH),
        .AW    (ROM_AW)
    ) u_rom (
        .clk   (clk),
        .we    (accept && dec.rom_we),
        .re    (accept && dec.rom_re),
        .addr  (dec.rom_addr[ROM_AW-1:0]),
        .wdata (dec.wdata),
        .q     (rom_q)
    );

    cbm_ram #(
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (accept && dec.ram_we),
        .re    (accept && dec.ram_re),
        .addr  (dec.ram_addr[RAM_AW-1:0]),
        .wdata (dec.wdata),
        .q     (ram_q),
        .busy  (clear_busy)
    );

    always_comb
    begin
        case (s1_src_reg)
            SRC_ROM: s1_data = rom_q;
            SRC_RAM: s1_data = ram_q;
            default: s1_data = FILL_BYTE;
        endcase

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_move)
        begin
            s2_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // memory read data stays put until the next request is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_reg    <= dec.src;
            s1_status_reg <= dec.status;
        end
        if (s1_move)
        begin
            s2_data_reg   <= s1_data;
            s2_status_reg <= s1_status_reg;
        end
    end

    assign rsp.valid     = s2_valid_reg;
    assign rsp.read_data = s2_data_reg;
    assign rsp.status    = s2_status_reg;

endmodule

@@ verif/cbm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_checker
// Watches the request, response and size-register ports of the cartridge
// bank mapper, keeps its own copy of the bank registers, ROM and RAM,
// works out the byte and status owed for every request taken, and compares
// each response against the oldest one owed.
// ----------------------------------------------------------------------------
module cbm_checker
    import cbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    cbm_req_if                    req,
    cbm_rsp_if                    rsp,
    output int                    fail_count,
    output int                    results_done,
    output int                    outstanding
);

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
    } mapped_rsp_t;

    logic [7:0] rom_image [0:(1 << ROM_ADDR_W) - 1];
    logic [7:0] ram_image [0:(1 << RAM_ADDR_W) - 1];

    logic       ram_on;
    logic [4:0] bank_sel;
    logic [1:0] upper_bits;
    logic       mode_adv;
    logic [2:0] rom_code;
    logic [1:0] ram_code;

    mapped_rsp_t rsp_due_q [$];

    function automatic int rom_limit();
        int n;
        n = 2 << rom_code;
        if (n > MAX_ROM_BANKS_DEF)
        begin
            n = MAX_ROM_BANKS_DEF;
        end
        return n << ROM_BANK_W;
    endfunction

    function automatic int ram_limit();
        case (ram_code)
            2'd2:    return 1 << RAM_BANK_W;
            2'd3:    return MAX_RAM_BANKS_DEF << RAM_BANK_W;
            default: return 0;
        endcase
    endfunction

    // ram bank follows the upper bits only in advanced mode
    function automatic int ram_index(input logic [15:0] a);
        int b;
        b = mode_adv ? int'(upper_bits) : 0;
        return (b << RAM_BANK_W) + int'(a[RAM_BANK_W-1:0]);
    endfunction

    function automatic mapped_rsp_t map_request(input cmd_t c, input logic [15:0] a,
                                                input logic [18:0] la, input logic [7:0] d);
        mapped_rsp_t r;
        int          idx;
        logic [4:0]  b;
        r.data   = FILL_BYTE;
        r.status = ST_OK;
        case (c)
            CMD_READ:
            begin
                case (window_t'(a[15:13]))
                    WIN_RAM_EN, WIN_ROM_BANK:
                    begin
                        idx = int'(a[ROM_BANK_W-1:0]);
                        if (mode_adv)
                        begin
                            idx += int'(upper_bits) << (ROM_BANK_W + 5);
                        end
                        if (idx < rom_limit())
                            r.data = rom_image[idx];
                        else
                            r.status = ST_ROM_RANGE;
                    end
                    WIN_UPPER, WIN_MODE:
                    begin
                        idx = (int'(bank_sel) << ROM_BANK_W) + int'(a[ROM_BANK_W-1:0]);
                        if (idx < rom_limit())
                            r.data = rom_image[idx];
                        else
                            r.status = ST_ROM_RANGE;
                    end
                    WIN_EXT_RAM:
                    begin
                        if (ram_on)
                        begin
                            idx = ram_index(a);
                            if (idx < ram_limit())
                                r.data = ram_image[idx];
                            else
                                r.status = ST_RAM_RANGE;
                        end
                    end
                    default:
                        r.status = ST_UNMAPPED;
                endcase
            end
            CMD_WRITE:
            begin
                case (window_t'(a[15:13]))
                    WIN_RAM_EN:
                        ram_on = (d[3:0] == RAM_EN_KEY);
                    WIN_ROM_BANK:
                    begin
                        b = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
                        // the modulo may land on bank 0, which is kept
                        bank_sel = 5'(int'(b) % (rom_limit() >> ROM_BANK_W));
                    end
                    WIN_UPPER:
                        upper_bits = d[1:0];
                    WIN_MODE:
                        mode_adv = d[0];
                    WIN_EXT_RAM:
                    begin
                        if (ram_on)
                        begin
                            idx = ram_index(a);
                            if (idx < ram_limit())
                                ram_image[idx] = d;
                            else
                                r.status = ST_RAM_RANGE;
                        end
                    end
                    default:
                        ;
                endcase
            end
            CMD_LOAD:
            begin
                if (int'(la) < rom_limit())
                    rom_image[la] = d;
                else
                    r.status = ST_ROM_RANGE;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void note_failure(input string what, input string want,
                                         input logic [7:0] got_data, input logic [1:0] got_st);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t %s: expected %s, got data %02h status %0d",
                     $time, what, want, got_data, got_st);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        mapped_rsp_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < (1 << RAM_ADDR_W); i++)
            begin
                ram_image[i] = 8'h00;
            end
            ram_on     = 1'b0;
            bank_sel   = 5'd1;
            upper_bits = 2'd0;
            mode_adv   = 1'b0;
            rom_code   = 3'd0;
            ram_code   = 2'd0;
            fail_count = 0;
            rsp_due_q.delete();
            results_done <= 0;
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_ROM_SIZE: rom_code = cfg_data;
                    CFG_RAM_SIZE: ram_code = cfg_data[1:0];
                    default:      ;
                endcase
            end
            // compare before pushing so a stray response never meets a fresh request
            if (rsp.valid && rsp.ready)
            begin
                results_done <= results_done + 1;
                if (rsp_due_q.size() == 0)
                begin
                    note_failure("unexpected response", "nothing", rsp.read_data, rsp.status);
                end
                else
                begin
                    e = rsp_due_q.pop_front();
                    if (rsp.read_data !== e.data || rsp.status !== e.status)
                    begin
                        note_failure("mismatch",
                                     $sformatf("data %02h status %0d", e.data, e.status),
                                     rsp.read_data, rsp.status);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                rsp_due_q.push_back(map_request(cmd_t'(req.cmd), req.bus_address,
                                                req.rom_load_address, req.data_byte));
            end
            outstanding <= rsp_due_q.size();
        end
    end

endmodule

@@ verif/cartridge_bank_mapper_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_test
// Drives the cartridge bank mapper: a ROM preload, a directed pass over the
// bank registers and windows, then random bus traffic under a series of
// ROM and RAM size settings with random stalls on both channels. The
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_test
    import cbm_pkg::*;
;

    localparam int N_PHASES     = 9;
    localparam int PHASE_ITEMS  = 42;
    localparam int LONG_HOLD    = 100;
    localparam int HOLD_PHASE   = 2;
    localparam int PAUSE_PHASE  = 4;

    localparam logic [2:0] ROM_CODES [N_PHASES] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
                                                    3'd7, 3'd5, 3'd6, 3'd4};
    localparam logic [2:0] RAM_CODES [N_PHASES] = '{3'd0, 3'd2, 3'd3, 3'd1, 3'd3,
                                                    3'd2, 3'd3, 3'd0, 3'd3};

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] addr;
        logic [18:0] laddr;
        logic [7:0]  data;
    } bus_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   fails;
    int   results_done;
    int   outstanding;
    int   sent      = 0;
    logic idle_on   = 1'b1;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    cbm_req_if req_ch ();
    cbm_rsp_if rsp_ch ();

    cartridge_bank_mapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    cbm_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fail_count   (fails),
        .results_done (results_done),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("timeout with %0d requests sent, %0d responses seen", sent, results_done);
        $display("Mismatches found");
        $finish;
    end

    // the preload fills only these in-bank offsets, so ROM reads stay on them
    function automatic logic [13:0] rom_offset();
        int r;
        r = $urandom_range(0, 7);
        return (r < 4) ? 14'(r) : 14'(16'h3FF8 + r);
    endfunction

    function automatic bus_req_t mk(input cmd_t c, input logic [15:0] a, input logic [7:0] d);
        bus_req_t it;
        it.cmd   = c;
        it.addr  = a;
        it.laddr = 19'($urandom);
        it.data  = d;
        return it;
    endfunction

    function automatic bus_req_t pick_setup();
        bus_req_t it;
        window_t  w;
        case ($urandom_range(0, 3))
            0:       w = WIN_RAM_EN;
            1:       w = WIN_ROM_BANK;
            2:       w = WIN_UPPER;
            default: w = WIN_MODE;
        endcase
        it = mk(CMD_WRITE, {w, 13'($urandom)}, 8'($urandom));
        if (w == WIN_RAM_EN && $urandom_range(0, 2) != 0)
        begin
            it.data[3:0] = RAM_EN_KEY;
        end
        return it;
    endfunction

    function automatic bus_req_t pick_access();
        bus_req_t it;
        window_t  w;
        int       sel;
        sel = $urandom_range(0, 99);
        it  = mk(CMD_READ, 16'($urandom), 8'($urandom));
        if (sel < 30)
        begin
            it.addr = {1'b0, 1'($urandom_range(0, 1)), rom_offset()};
        end
        else if (sel < 45)
        begin
            it.addr = {WIN_EXT_RAM, 13'($urandom)};
        end
        else if (sel < 62)
        begin
            it.cmd  = CMD_WRITE;
            it.addr = {WIN_EXT_RAM, 13'($urandom)};
        end
        else if (sel < 72)
        begin
            it = pick_setup();
        end
        else if (sel < 80)
        begin
            case ($urandom_range(0, 3))
                0:       w = WIN_VRAM;
                1:       w = WIN_WRAM;
                default: w = WIN_HIGH;
            endcase
            it.addr = {w, 13'($urandom)};
            if ($urandom_range(0, 1) == 1)
            begin
                it.cmd = CMD_WRITE;
            end
        end
        else if (sel < 90)
        begin
            it.cmd = CMD_LOAD;
            if ($urandom_range(0, 1) == 1)
            begin
                it.laddr = 19'($urandom_range(0, 32767));
            end
        end
        else if (sel < 94)
        begin
            it.cmd = CMD_NONE;
        end
        else
        begin
            it.cmd = CMD_WRITE;
        end
        return it;
    endfunction

    task automatic send_item(input bus_req_t it);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.cmd              <= it.cmd;
        req_ch.bus_address      <= it.addr;
        req_ch.rom_load_address <= it.laddr;
        req_ch.data_byte        <= it.data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_done != sent);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [2:0] rom_c, input logic [2:0] ram_c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROM_SIZE;
        cfg_data  <= rom_c;
        @(posedge clk);
        cfg_index <= CFG_RAM_SIZE;
        cfg_data  <= ram_c;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (hold_req && !hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = LONG_HOLD - 1;
                hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        bus_req_t it;
        int       phase_items;
        logic     paused;
        paused                  = 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.cmd              <= CMD_NONE;
        req_ch.bus_address      <= 16'h0000;
        req_ch.rom_load_address <= 19'h00000;
        req_ch.data_byte        <= 8'h00;
        cfg_we                  <= 1'b0;
        cfg_index               <= CFG_ROM_SIZE;
        cfg_data                <= '0;
        rst_n                   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // largest ROM and RAM while the RAM sweep runs
        write_sizes(3'd4, 3'd3);

        for (int b = 0; b < MAX_ROM_BANKS_DEF; b++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                it       = mk(CMD_LOAD, 16'($urandom), 8'($urandom));
                it.laddr = {5'(b), (r < 4) ? 14'(r) : 14'(16'h3FF8 + r)};
                send_item(it);
            end
        end

        // directed pass: windows, register edges, RAM enable, advanced mode
        send_item(mk(CMD_READ,  16'h0000, 8'h00));
        send_item(mk(CMD_READ,  16'h3FFF, 8'hFF));
        send_item(mk(CMD_READ,  16'h4000, 8'h00));
        send_item(mk(CMD_READ,  16'h7FFF, 8'hFF));
        send_item(mk(CMD_READ,  16'hA000, 8'h00));
        send_item(mk(CMD_WRITE, 16'hA000, 8'h11));
        send_item(mk(CMD_WRITE, 16'h0000, 8'h0A));
        send_item(mk(CMD_WRITE, 16'hA000, 8'h5A));
        send_item(mk(CMD_WRITE, 16'hBFFF, 8'hC3));
        send_item(mk(CMD_READ,  16'hA000, 8'h00));
        send_item(mk(CMD_READ,  16'hBFFF, 8'h00));
        send_item(mk(CMD_WRITE, 16'h2000, 8'h00));
        send_item(mk(CMD_READ,  16'h4003, 8'h00));
        send_item(mk(CMD_WRITE, 16'h3FFF, 8'hFF));
        send_item(mk(CMD_READ,  16'h7FFC, 8'h00));
        send_item(mk(CMD_WRITE, 16'h4000, 8'hFF));
        send_item(mk(CMD_WRITE, 16'h7FFF, 8'h01));
        send_item(mk(CMD_READ,  16'h0000, 8'h00));
        send_item(mk(CMD_WRITE, 16'hA001, 8'h77));
        send_item(mk(CMD_READ,  16'hA001, 8'h00));
        send_item(mk(CMD_READ,  16'h8000, 8'h00));
        send_item(mk(CMD_READ,  16'hFFFF, 8'h00));
        send_item(mk(CMD_WRITE, 16'hC000, 8'hAA));
        it       = mk(CMD_LOAD, 16'hFFFF, 8'h00);
        it.laddr = 19'h7FFFF;
        send_item(it);
        send_item(mk(CMD_NONE,  16'hFFFF, 8'hFF));
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p == N_PHASES - 1)
            begin
                idle_on = 1'b0;
            end
            if (p == HOLD_PHASE)
            begin
                hold_req = 1'b1;
            end
            write_sizes(ROM_CODES[p], RAM_CODES[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        send_item(pick_setup());
                        phase_items++;
                    end
                end
                repeat ($urandom_range(3, 8))
                begin
                    send_item(pick_access());
                    phase_items++;
                end
                // sender waits for every response in the middle of a phase
                if (p == PAUSE_PHASE && !paused && phase_items > 30)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        repeat (8) @(posedge clk);
        $display("covered %0d requests: ROM preload, directed window cases, random traffic",
                 sent);
        $display("over %0d ROM/RAM size settings, with stalls and one long response hold",
                 N_PHASES + 1);
        if (fails == 0 && outstanding == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
